// ----- rtl/core/mrfp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrfp_pkg: shared types and constants of the motor reply frame parser
// Holds the frame markers, the frame lengths, the frame kind codes and the
// structures passed between the top level and the frame decoder.
// ----------------------------------------------------------------------------
package mrfp_pkg;

  localparam logic [7:0] END_MARK     = 8'h6B;
  localparam logic [7:0] CODE_ENCODER = 8'h30;
  localparam logic [7:0] CODE_GAINS   = 8'h21;
  localparam logic [7:0] ADDR_RESET   = 8'h01;

  // Frame lengths in bytes, address and end mark included.
  localparam int unsigned ENC_LEN  = 5;
  localparam int unsigned POS_LEN  = 6;
  localparam int unsigned GAIN_LEN = 19;

  // The decoder sees the newest GAIN_LEN bytes; tap 0 is the newest.
  localparam int unsigned TAP_COUNT = GAIN_LEN;

  localparam logic [1:0] KIND_ENCODER  = 2'd0;
  localparam logic [1:0] KIND_POSITION = 2'd1;
  localparam logic [1:0] KIND_GAINS    = 2'd2;

  typedef logic [TAP_COUNT-1:0][7:0] mrfp_taps_t;

  // Which frame lengths fit into the bytes stored since the last clear.
  typedef struct packed {
    logic enc_len_ok;
    logic pos_len_ok;
    logic gain_len_ok;
  } mrfp_len_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] position;
    logic [31:0] traj_position_gain;
    logic [31:0] bypass_position_gain;
    logic [31:0] speed_gain_p;
    logic [31:0] speed_gain_i;
  } mrfp_result_t;

endpackage

// ----- rtl/core/mrfp_decode.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrfp_decode: reply frame matcher
// Checks the newest bytes for an encoder, position or gain reply, in that
// priority order, and assembles the result fields of the first match.
// ----------------------------------------------------------------------------
module mrfp_decode
  import mrfp_pkg::*;
(
  input  mrfp_taps_t   taps_i,
  input  mrfp_len_t    len_i,
  input  logic [7:0]   addr_i,
  output logic         match_o,
  output mrfp_result_t result_o
);

  // Big-endian word whose most significant byte sits at tap hi.
  function automatic logic [31:0] word_at(input mrfp_taps_t t, input int unsigned hi);
    return {t[hi], t[hi-1], t[hi-2], t[hi-3]};
  endfunction

  logic end_ok;
  logic enc_hit;
  logic pos_hit;
  logic gain_hit;

  assign end_ok   = (taps_i[0] == END_MARK);
  assign enc_hit  = len_i.enc_len_ok && end_ok && (taps_i[ENC_LEN-1] == addr_i) &&
                    (taps_i[ENC_LEN-2] == CODE_ENCODER);
  // The position reply carries no function code.
  assign pos_hit  = len_i.pos_len_ok && end_ok && (taps_i[POS_LEN-1] == addr_i);
  assign gain_hit = len_i.gain_len_ok && end_ok && (taps_i[GAIN_LEN-1] == addr_i) &&
                    (taps_i[GAIN_LEN-2] == CODE_GAINS);

  assign match_o = enc_hit || pos_hit || gain_hit;

  always_comb begin
    result_o = '0;
    if (enc_hit) begin
      result_o.kind     = KIND_ENCODER;
      result_o.position = {16'h0000, taps_i[2], taps_i[1]};
    end else if (pos_hit) begin
      result_o.kind     = KIND_POSITION;
      result_o.position = word_at(taps_i, 4);
    end else if (gain_hit) begin
      result_o.kind                 = KIND_GAINS;
      result_o.traj_position_gain   = word_at(taps_i, 16);
      result_o.bypass_position_gain = word_at(taps_i, 12);
      result_o.speed_gain_p         = word_at(taps_i, 8);
      result_o.speed_gain_i         = word_at(taps_i, 4);
    end
  end

endmodule

// ----- rtl/core/motor_reply_frame_parser.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// motor_reply_frame_parser: servo reply frame parser for one axis
// Collects received serial bytes and reports encoder, position and gain
// replies addressed to the configured device.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Fields (lowest bits first)
//  -------   ---------  ---------------------------------------------------
//  s_axis    in         tdata: rx_byte[7:0]
//  m_axis    out        tdata: position, traj_position_gain,
//                              bypass_position_gain, speed_gain_p,
//                              speed_gain_i (32 bits each); tuser: frame_kind
//  cfg       in         cfg_data_i: device_address[7:0]
//
//  One byte is taken in every cycle while the skid register is empty. The frame
//  check is combinational on the byte history and the byte that closes a frame;
//  its result is registered in the output register, or in the skid register.
//  Reset clears the byte count and sets the device address to 1.
//  While a result waits, one more result can be held in a skid register;
//  s_axis_tready falls only while that skid register is occupied.
//
// The byte history is kept as a shift line of the newest bytes, together
// with the number of bytes stored since the last clear. Every entry below
// that count has been written since the clear, so the shift line gives the
// same bytes as a fill buffer indexed by the count. The count wraps to zero
// at STORE_DEPTH, dropping the stored bytes.
module motor_reply_frame_parser
  import mrfp_pkg::*;
#(
  parameter int unsigned STORE_DEPTH = 30
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // rx_byte
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [159:0] m_axis_tdata,   // position, traj_position_gain,
                                       // bypass_position_gain, speed_gain_p,
                                       // speed_gain_i
  output logic [7:0]   m_axis_tuser,   // frame_kind, zero filled
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [7:0]   cfg_data_i      // device_address
);

  localparam int unsigned CNT_W = $clog2(STORE_DEPTH + 1);

  logic [7:0]   addr_q;
  logic [CNT_W-1:0] count_q, count_d, count_inc;
  mrfp_taps_t   taps_q, taps_d;
  mrfp_len_t    len;
  logic         match;
  mrfp_result_t result;
  logic         accept;
  logic         res_valid;
  logic         take;

  mrfp_result_t out_q, skid_q;
  logic         out_valid_q, out_valid_d;
  logic         skid_valid_q, skid_valid_d;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !skid_valid_q;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign take          = m_axis_tvalid && m_axis_tready;

  // Device address register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q <= ADDR_RESET;
    end else if (cfg_valid_i) begin
      addr_q <= cfg_data_i;
    end
  end

  // Byte history: the newest byte enters tap 0.
  assign taps_d    = {taps_q[TAP_COUNT-2:0], s_axis_tdata};
  assign count_inc = count_q + CNT_W'(1);

  assign len.enc_len_ok  = (count_inc >= CNT_W'(ENC_LEN));
  assign len.pos_len_ok  = (count_inc >= CNT_W'(POS_LEN));
  assign len.gain_len_ok = (count_inc >= CNT_W'(GAIN_LEN));

  mrfp_decode u_decode (
    .taps_i   (taps_d),
    .len_i    (len),
    .addr_i   (addr_q),
    .match_o  (match),
    .result_o (result)
  );

  assign res_valid = accept && match;

  // A match clears the count; otherwise it wraps at the store depth.
  always_comb begin
    count_d = count_q;
    if (accept) begin
      if (match || (count_inc >= CNT_W'(STORE_DEPTH))) begin
        count_d = '0;
      end else begin
        count_d = count_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      taps_q <= taps_d;
    end
  end

  // Output register with one skid entry behind it. The skid entry fills only
  // when a new result arrives while the output is held.
  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    if (skid_valid_q) begin
      if (take) begin
        skid_valid_d = 1'b0;
      end
    end else if (res_valid) begin
      if (out_valid_q && !take) begin
        skid_valid_d = 1'b1;
      end else begin
        out_valid_d = 1'b1;
      end
    end else if (take) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (take) begin
        out_q <= skid_q;
      end
    end else if (res_valid) begin
      if (out_valid_q && !take) begin
        skid_q <= result;
      end else begin
        out_q <= result;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_q.speed_gain_i, out_q.speed_gain_p,
                          out_q.bypass_position_gain, out_q.traj_position_gain,
                          out_q.position};
  assign m_axis_tuser  = {6'b000000, out_q.kind};

endmodule

// ----- rtl/core/mrfp_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrfp_checker: port-level checks of the motor reply frame parser
// Watches the top level's ports and flags protocol and result-format slips.
// ----------------------------------------------------------------------------
module mrfp_checker
  import mrfp_pkg::*;
(
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic [7:0]   s_axis_tdata,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [159:0] m_axis_tdata,
  input logic [7:0]   m_axis_tuser
);

  // A stalled result stays offered.
  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result withdrawn while stalled");

  // A fresh result can only follow a byte that was an end mark.
  a_end_mark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |->
      $past(s_axis_tvalid && s_axis_tready && (s_axis_tdata == END_MARK)))
    else $error("result without a closing end mark");

  // Only the three frame kinds are ever reported.
  a_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser[7:2] == 6'd0) && (m_axis_tuser[1:0] != 2'd3))
    else $error("bad frame kind");

  // Encoder and position replies carry no gains; encoder values are 16 bits.
  a_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser[1:0] != KIND_GAINS) |->
      (m_axis_tdata[159:32] == '0) &&
      ((m_axis_tuser[1:0] != KIND_ENCODER) || (m_axis_tdata[31:16] == 16'd0)))
    else $error("unused result fields not zero");

endmodule

bind motor_reply_frame_parser mrfp_checker u_mrfp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

// ----- sim/tb_motor_reply_frame_parser.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_motor_reply_frame_parser: self-checking bench for the reply frame parser
// Streams received bytes into the parser and compares every reply item that
// it emits with a cycle-free model of the byte store and the three frame
// checks. A short table of hand-made frames comes first. Random phases under
// several device addresses follow, with random stalls on both streams except in the last phase.
// ----------------------------------------------------------------------------
module tb_motor_reply_frame_parser;
  import mrfp_pkg::*;

  localparam int unsigned STORE_DEPTH   = 30;
  localparam int          DIR_ROWS      = 31;
  localparam int          NUM_PHASES    = 6;
  localparam int          PHASE_BYTES   = 130;
  // The frame check is combinational and only results are registered, so a byte
  // that closes no frame leaves nothing behind in the pipeline.
  localparam int          SETTLE_CYCLES = 4;
  localparam int          TAIL_CYCLES   = 20;
  localparam int          HOLD_CYCLES   = 80;
  // The longest correct stretch without any handshake is the long receiver
  // hold. The watchdog allows many times that.
  localparam int          WATCHDOG_LIMIT = 2000;
  localparam int          PRINT_LIMIT    = 40;

  // Ways in which a random frame is spoilt on purpose.
  typedef enum logic [1:0] {
    FLAW_END,
    FLAW_ADDR,
    FLAW_CODE,
    FLAW_CUT
  } flaw_t;

  // One row of the directed table. Where known is set, the reply that the
  // row closes is written out by hand and replaces the predicted one.
  typedef struct packed {
    logic [7:0]   rx;
    logic         known;
    mrfp_result_t reply;
  } stim_row_t;

  localparam mrfp_result_t NO_REPLY = '0;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata;   // rx_byte
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [159:0] m_axis_tdata;   // position, traj_position_gain,
                                // bypass_position_gain, speed_gain_p,
                                // speed_gain_i (32 bits each)
  logic [7:0]   m_axis_tuser;   // frame_kind, zero filled
  logic         cfg_valid_i;
  logic         cfg_ready_o;
  logic [7:0]   cfg_data_i;     // device_address

  motor_reply_frame_parser #(
    .STORE_DEPTH(STORE_DEPTH)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  // Shadow of the parser state: the fill store, the fill count and the
  // configured device address.
  logic [7:0]   rx_history [STORE_DEPTH];
  int           rx_fill;
  logic [7:0]   dev_addr;

  // Replies still owed by the parser, oldest first.
  mrfp_result_t pending_replies [$];

  int           mismatch_count;
  int           bytes_sent;
  int           address_writes;
  int           replies_seen [3];
  int           stall_cycles;
  int           holds_done;
  bit           hold_request;
  bit           hold_active;
  bit           no_idle;
  mrfp_result_t seen_reply;
  mrfp_result_t want_reply;

  // Hand-made frames for the reset address 1. The first one also closes a
  // position frame, since the byte six back is the address too; the encoder
  // check comes first and so decides. The others carry the extreme values of
  // the position and of the four gains.
  stim_row_t directed_rows [DIR_ROWS] = '{
    '{8'h01, 1'b0, NO_REPLY},
    '{8'h01, 1'b0, NO_REPLY},
    '{8'h30, 1'b0, NO_REPLY},
    '{8'hFF, 1'b0, NO_REPLY},
    '{8'hFF, 1'b0, NO_REPLY},
    '{8'h6B, 1'b1, '{KIND_ENCODER, 32'h0000_FFFF, 32'h0, 32'h0, 32'h0, 32'h0}},
    '{8'h01, 1'b0, NO_REPLY},
    '{8'h80, 1'b0, NO_REPLY},
    '{8'h00, 1'b0, NO_REPLY},
    '{8'h00, 1'b0, NO_REPLY},
    '{8'h00, 1'b0, NO_REPLY},
    '{8'h6B, 1'b1, '{KIND_POSITION, 32'h8000_0000, 32'h0, 32'h0, 32'h0, 32'h0}},
    '{8'h01, 1'b0, NO_REPLY},
    '{8'h21, 1'b0, NO_REPLY},
    '{8'h7F, 1'b0, NO_REPLY},
    '{8'hFF, 1'b0, NO_REPLY},
    '{8'hFF, 1'b0, NO_REPLY},
    '{8'hFF, 1'b0, NO_REPLY},
    '{8'h80, 1'b0, NO_REPLY},
    '{8'h00, 1'b0, NO_REPLY},
    '{8'h00, 1'b0, NO_REPLY},
    '{8'h00, 1'b0, NO_REPLY},
    '{8'h00, 1'b0, NO_REPLY},
    '{8'h00, 1'b0, NO_REPLY},
    '{8'h00, 1'b0, NO_REPLY},
    '{8'h00, 1'b0, NO_REPLY},
    '{8'hFF, 1'b0, NO_REPLY},
    '{8'hFF, 1'b0, NO_REPLY},
    '{8'hFF, 1'b0, NO_REPLY},
    '{8'hFF, 1'b0, NO_REPLY},
    '{8'h6B, 1'b1, '{KIND_GAINS, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000,
                     32'h0000_0000, 32'hFFFF_FFFF}}
  };

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Big-endian 32-bit word starting at store entry i.
  function automatic logic [31:0] word_at(input int i);
    return {rx_history[i], rx_history[i+1], rx_history[i+2], rx_history[i+3]};
  endfunction

  // Stores one byte and runs the three frame checks in their fixed order on
  // the bytes that end with it. Returns 1 and the reply when a frame closes.
  function automatic logic predict_reply(input logic [7:0] rx, output mrfp_result_t r);
    int n;
    r = '0;
    if (rx_fill >= STORE_DEPTH) rx_fill = 0;
    rx_history[rx_fill] = rx;
    rx_fill++;
    n = rx_fill;
    if (n >= ENC_LEN && rx_history[n-1] == END_MARK && rx_history[n-5] == dev_addr &&
        rx_history[n-4] == CODE_ENCODER) begin
      r.kind     = KIND_ENCODER;
      r.position = {16'h0, rx_history[n-3], rx_history[n-2]};
      rx_fill    = 0;
      return 1'b1;
    end
    // No function code is checked for the position reply.
    if (n >= POS_LEN && rx_history[n-1] == END_MARK && rx_history[n-6] == dev_addr) begin
      r.kind     = KIND_POSITION;
      r.position = word_at(n - 5);
      rx_fill    = 0;
      return 1'b1;
    end
    if (n >= GAIN_LEN && rx_history[n-1] == END_MARK && rx_history[n-19] == dev_addr &&
        rx_history[n-18] == CODE_GAINS) begin
      r.kind                 = KIND_GAINS;
      r.traj_position_gain   = word_at(n - 17);
      r.bypass_position_gain = word_at(n - 13);
      r.speed_gain_p         = word_at(n - 9);
      r.speed_gain_i         = word_at(n - 5);
      rx_fill                = 0;
      return 1'b1;
    end
    // Nothing matched: a full store is dropped as a whole.
    if (rx_fill >= STORE_DEPTH) rx_fill = 0;
    return 1'b0;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  // Every mismatch is counted; only the first few are printed so that a badly
  // broken block cannot flood the log.
  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= PRINT_LIMIT) $display("%0t mismatch: %s", $realtime, msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %08h, expected %08h", name, got, want));
  endtask

  // Outputs are sampled at the falling edge before the edge that takes the item,
  // when everything driven at the previous edge has settled. The receiver only
  // changes tready at a rising edge, so an item seen here is taken at the next
  // edge without fail.
  always @(negedge clk_i) begin
    if (rst_ni === 1'b1 && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) begin
      seen_reply.kind                 = m_axis_tuser[1:0];
      seen_reply.position             = m_axis_tdata[31:0];
      seen_reply.traj_position_gain   = m_axis_tdata[63:32];
      seen_reply.bypass_position_gain = m_axis_tdata[95:64];
      seen_reply.speed_gain_p         = m_axis_tdata[127:96];
      seen_reply.speed_gain_i         = m_axis_tdata[159:128];
      if (pending_replies.size() == 0) begin
        report_mismatch($sformatf("kind %0d reply with nothing expected", seen_reply.kind));
      end else begin
        want_reply = pending_replies.pop_front();
        check_field("frame_kind", 32'(seen_reply.kind), 32'(want_reply.kind));
        check_field("position", seen_reply.position, want_reply.position);
        check_field("traj_position_gain", seen_reply.traj_position_gain,
                    want_reply.traj_position_gain);
        check_field("bypass_position_gain", seen_reply.bypass_position_gain,
                    want_reply.bypass_position_gain);
        check_field("speed_gain_p", seen_reply.speed_gain_p, want_reply.speed_gain_p);
        check_field("speed_gain_i", seen_reply.speed_gain_i, want_reply.speed_gain_i);
        if (want_reply.kind <= KIND_GAINS) replies_seen[want_reply.kind]++;
      end
    end
  end

  // Watchdog: counts cycles in which no handshake of any channel completes.
  always @(negedge clk_i) begin
    if ((s_axis_tvalid === 1'b1 && s_axis_tready === 1'b1) ||
        (m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) ||
        (cfg_valid_i === 1'b1 && cfg_ready_o === 1'b1)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no item moved for %0d cycles, %0d replies still owed.",
               WATCHDOG_LIMIT, pending_replies.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver
  // ---------------------------------------------------------------------------

  // Ready runs of random length, broken by short stalls. A hold request from
  // the sender side turns into one long stall, during which the parser fills
  // its output and skid registers and has to stop taking bytes.
  initial begin : receiver
    int ready_run;
    m_axis_tready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        hold_active  = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_active = 1'b0;
        holds_done++;
      end else if (!no_idle && $urandom_range(0, 2) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      ready_run = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6);
      repeat (ready_run) @(posedge clk_i);
    end
  end

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------

  // Offers one byte, possibly after a short gap, and waits until it is taken.
  // The shadow store is updated at the edge that takes the byte.
  task automatic send_byte(input logic [7:0] rx, input logic known,
                           input mrfp_result_t known_reply);
    mrfp_result_t r;
    logic         hit;
    if (!no_idle && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= 8'($urandom_range(0, 255));
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= rx;
    do @(negedge clk_i); while (s_axis_tready !== 1'b1);
    @(posedge clk_i);
    bytes_sent++;
    hit = predict_reply(rx, r);
    if (known) pending_replies.push_back(known_reply);
    else if (hit) pending_replies.push_back(r);
  endtask

  task automatic send_seq(input logic [7:0] seq [$]);
    foreach (seq[i]) send_byte(seq[i], 1'b0, NO_REPLY);
  endtask

  // Stops offering bytes and waits until every owed reply has been taken and
  // the frame check stage has gone quiet.
  task automatic wait_for_replies();
    s_axis_tvalid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_address(input logic [7:0] addr);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= addr;
    do @(negedge clk_i); while (cfg_ready_o !== 1'b1);
    @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    dev_addr = addr;
    address_writes++;
  endtask

  function automatic logic [7:0] any_but(input logic [7:0] x);
    logic [7:0] v;
    do v = 8'($urandom_range(0, 255)); while (v == x);
    return v;
  endfunction

  // Payload byte, leaning towards the values at the sign and range edges.
  function automatic logic [7:0] payload_byte();
    logic [7:0] edges [4] = '{8'h00, 8'hFF, 8'h7F, 8'h80};
    if ($urandom_range(0, 3) == 0) return edges[$urandom_range(0, 3)];
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic build_frame(input logic [1:0] kind, input logic [7:0] addr,
                             output logic [7:0] seq [$]);
    seq = {};
    seq.push_back(addr);
    case (kind)
      KIND_ENCODER: begin
        seq.push_back(CODE_ENCODER);
        repeat (2) seq.push_back(payload_byte());
      end
      KIND_POSITION: begin
        repeat (4) seq.push_back(payload_byte());
      end
      default: begin
        seq.push_back(CODE_GAINS);
        repeat (16) seq.push_back(payload_byte());
      end
    endcase
    seq.push_back(END_MARK);
  endtask

  // One random unit of traffic: mostly well-formed frames for the current
  // address, then spoilt frames, short bursts of noise and long runs without
  // an end mark that push the fill count round its wrap.
  task automatic send_random_unit();
    logic [7:0] seq [$];
    int         pick;
    flaw_t      flaw;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      build_frame(pick < 24 ? KIND_ENCODER : pick < 48 ? KIND_POSITION : KIND_GAINS,
                  dev_addr, seq);
    end else if (pick < 82) begin
      build_frame(2'($urandom_range(0, 2)), dev_addr, seq);
      flaw = flaw_t'($urandom_range(0, 3));
      case (flaw)
        FLAW_END:  seq[seq.size()-1] = any_but(END_MARK);
        FLAW_ADDR: seq[0] = any_but(dev_addr);
        FLAW_CODE: seq[1] = any_but(seq[1]);
        default:   repeat ($urandom_range(1, seq.size() - 1)) void'(seq.pop_back());
      endcase
    end else if (pick < 94) begin
      repeat ($urandom_range(1, 6)) seq.push_back(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(STORE_DEPTH, STORE_DEPTH + 10)) seq.push_back(any_but(END_MARK));
    end
    send_seq(seq);
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    logic [7:0]   phase_addr [NUM_PHASES];
    int           target;
    mrfp_result_t leftover;

    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= 8'h00;
    cfg_valid_i   <= 1'b0;
    cfg_data_i    <= 8'h00;
    rx_fill        = 0;
    dev_addr       = ADDR_RESET;
    mismatch_count = 0;
    bytes_sent     = 0;
    address_writes = 0;
    stall_cycles   = 0;
    holds_done     = 0;
    hold_request   = 1'b0;
    hold_active    = 1'b0;
    no_idle        = 1'b0;
    replies_seen   = '{0, 0, 0};
    // Both address extremes, the end mark and the encoder code as addresses,
    // a random one, and back to the reset value at the end.
    phase_addr = '{8'h00, 8'hFF, CODE_ENCODER, END_MARK,
                   8'($urandom_range(0, 255)), ADDR_RESET};

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed frames under the reset address.
    for (int row = 0; row < DIR_ROWS; row++)
      send_byte(directed_rows[row].rx, directed_rows[row].known, directed_rows[row].reply);

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      // The address only changes while the parser has nothing in flight.
      wait_for_replies();
      write_address(phase_addr[phase]);
      if (phase == 1) hold_request = 1'b1;
      // The last phase runs at full rate on both sides.
      if (phase == NUM_PHASES - 1) no_idle = 1'b1;
      target = bytes_sent + PHASE_BYTES;
      // Keep offering bytes for as long as the long receiver hold lasts.
      while (bytes_sent < target || hold_request || hold_active) send_random_unit();
    end

    wait_for_replies();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    while (pending_replies.size() != 0) begin
      leftover = pending_replies.pop_front();
      report_mismatch($sformatf("kind %0d reply never arrived", leftover.kind));
    end

    $display("Covered %0d received bytes under %0d device address settings.",
             bytes_sent, address_writes + 1);
    $display("Checked %0d encoder, %0d position and %0d gain replies; %0d long hold(s).",
             replies_seen[KIND_ENCODER], replies_seen[KIND_POSITION],
             replies_seen[KIND_GAINS], holds_done);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches.", mismatch_count);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/mrfp_pkg.sv
rtl/core/mrfp_decode.sv
rtl/core/motor_reply_frame_parser.sv
rtl/core/mrfp_checker.sv
sim/tb_motor_reply_frame_parser.sv
